### sv/otrs_pkg.sv
// types, codes and helpers shared by the one-wire temperature read sequencer
package otrs_pkg;

  typedef enum logic [3:0] {
    PH_INIT       = 4'd0,
    PH_RST_WRITE  = 4'd1,
    PH_CONV_CC    = 4'd2,
    PH_CONV_44    = 4'd3,
    PH_CONV_BEGIN = 4'd4,
    PH_CONV_WAIT  = 4'd5,
    PH_RST_READ   = 4'd6,
    PH_READ_CC    = 4'd7,
    PH_READ_BE    = 4'd8,
    PH_READ_LO    = 4'd9,
    PH_READ_HI    = 4'd10,
    PH_READY      = 4'd11,
    PH_ERROR      = 4'd12
  } phase_t;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [1:0] BUS_READY = 2'd0;
  localparam logic [1:0] BUS_ERROR = 2'd2;

  localparam logic       MODE_POLL  = 1'b0;
  localparam logic       MODE_START = 1'b1;

  localparam logic [1:0] SENS_INIT  = 2'd0;
  localparam logic [1:0] SENS_BUSY  = 2'd1;
  localparam logic [1:0] SENS_READY = 2'd2;
  localparam logic [1:0] SENS_ERROR = 2'd3;

  localparam logic [7:0] ROM_SKIP   = 8'hCC;
  localparam logic [7:0] CONVERT_T  = 8'h44;
  localparam logic [7:0] READ_SCRAT = 8'hBE;

  localparam logic [31:0] CONVERT_WAIT_RST = 32'd750000;

  typedef struct packed {
    logic        mode;
    logic [1:0]  bus_state;
    logic [7:0]  bus_rx_byte;
    logic [31:0] clock_now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         bus_command;
    logic [7:0]         bus_tx_byte;
    logic [1:0]         sensor_state;
    logic signed [15:0] temperature;
  } result_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] wait_start;
    logic [7:0]  raw_lo;
    logic [15:0] last_temp;
  } seq_state_t;

  function automatic logic [1:0] status_of(phase_t ph);
    logic [1:0] s;
    unique case (ph)
      PH_INIT:  s = SENS_INIT;
      PH_READY: s = SENS_READY;
      PH_ERROR: s = SENS_ERROR;
      default:  s = SENS_BUSY;
    endcase
    return s;
  endfunction

endpackage

### sv/otrs_step.sv
// next-state and result logic for one word of the read sequencer
module otrs_step
  import otrs_pkg::*;
(
  input  seq_state_t  st,
  input  in_item_t    item,
  input  logic [31:0] convert_wait,
  output seq_state_t  st_nxt,
  output result_t     res
);

  logic [1:0]  cmd;
  logic [7:0]  tx;
  logic [31:0] elapsed;

  assign elapsed = item.clock_now - st.wait_start;

  always_comb begin
    st_nxt = st;
    cmd    = CMD_NONE;
    tx     = 8'h00;
    if (item.mode == MODE_START) begin
      if (st.phase == PH_INIT || st.phase == PH_READY || st.phase == PH_ERROR) begin
        st_nxt.raw_lo = 8'h00;
        st_nxt.phase  = PH_RST_WRITE;
        cmd           = CMD_RESET;
      end
    end else if (item.bus_state == BUS_ERROR) begin
      st_nxt.phase = PH_ERROR;
    end else if (item.bus_state == BUS_READY) begin
      unique case (st.phase)
        PH_RST_WRITE: begin
          st_nxt.phase = PH_CONV_CC;
          cmd          = CMD_WRITE;
          tx           = ROM_SKIP;
        end
        PH_CONV_CC: begin
          st_nxt.phase = PH_CONV_44;
          cmd          = CMD_WRITE;
          tx           = CONVERT_T;
        end
        PH_CONV_44: begin
          st_nxt.phase = PH_CONV_BEGIN;
        end
        PH_CONV_BEGIN: begin
          st_nxt.wait_start = item.clock_now;
          st_nxt.phase      = PH_CONV_WAIT;
        end
        PH_CONV_WAIT: begin
          if (elapsed >= convert_wait) begin
            st_nxt.phase = PH_RST_READ;
            cmd          = CMD_RESET;
          end
        end
        PH_RST_READ: begin
          st_nxt.phase = PH_READ_CC;
          cmd          = CMD_WRITE;
          tx           = ROM_SKIP;
        end
        PH_READ_CC: begin
          st_nxt.phase = PH_READ_BE;
          cmd          = CMD_WRITE;
          tx           = READ_SCRAT;
        end
        PH_READ_BE: begin
          st_nxt.phase = PH_READ_LO;
          cmd          = CMD_READ;
        end
        PH_READ_LO: begin
          st_nxt.raw_lo = item.bus_rx_byte;
          st_nxt.phase  = PH_READ_HI;
          cmd           = CMD_READ;
        end
        PH_READ_HI: begin
          st_nxt.last_temp = {item.bus_rx_byte, st.raw_lo};
          st_nxt.phase     = PH_READY;
        end
        default: begin
        end
      endcase
    end
  end

  assign res.bus_command  = cmd;
  assign res.bus_tx_byte  = tx;
  assign res.sensor_state = status_of(st_nxt.phase);
  assign res.temperature  = $signed(st_nxt.last_temp);

endmodule

### sv/onewire_temp_read_sequencer.sv
// top level of the one-wire temperature read sequencer
//
// Each input word is either a start request (in_tuser high) or a poll that
// carries the bus status, the last received byte and the free-running
// microsecond clock. Every accepted word yields exactly one output word with
// the bus operation to launch next, the byte to send, the sensor status and
// the last completed reading as signed 1/16 degree C. A word is held
// in the input register and is then folded into the sequencer state by
// combinational logic, landing in the output register; one word per cycle is
// sustained while the output side keeps taking words. Output valid is set
// when the word advances from the input register, which stalls while the
// output register holds an untaken word. The conversion wait is set through the
// cfg port in clock units (reset 750000) and compared against the wrapped
// difference of the clock field.
module onewire_temp_read_sequencer
  import otrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // bus_state[1:0], bus_rx_byte[9:2], clock_now[41:10], [47:42] unused
  input  logic        in_tuser,  // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // bus_command[1:0], bus_tx_byte[9:2],
                                 // sensor_state[11:10], temperature[27:12], zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        out_valid_r;
  result_t     out_res_r;
  seq_state_t  st_r;
  seq_state_t  st_nxt;
  result_t     res_nxt;
  logic [31:0] convert_wait_r;
  logic        advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  otrs_step u_step (
    .st           (st_r),
    .item         (in_item_r),
    .convert_wait (convert_wait_r),
    .st_nxt       (st_nxt),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      convert_wait_r <= CONVERT_WAIT_RST;
      st_r.phase     <= PH_INIT;
      st_r.wait_start <= 32'd0;
      st_r.raw_lo    <= 8'd0;
      st_r.last_temp <= 16'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        convert_wait_r <= cfg_data;
      end
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.mode        <= in_tuser;
      in_item_r.bus_state   <= in_tdata[1:0];
      in_item_r.bus_rx_byte <= in_tdata[9:2];
      in_item_r.clock_now   <= in_tdata[41:10];
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.temperature, out_res_r.sensor_state,
                       out_res_r.bus_tx_byte, out_res_r.bus_command};

`ifndef SYNTHESIS
  a_cmd_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.bus_command != CMD_NONE) |->
      (out_res_r.sensor_state == SENS_BUSY))
    else $error("bus command issued while sensor not busy");

  a_write_byte_known: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.bus_command == CMD_WRITE) |->
      (out_res_r.bus_tx_byte == ROM_SKIP || out_res_r.bus_tx_byte == CONVERT_T ||
       out_res_r.bus_tx_byte == READ_SCRAT))
    else $error("unexpected write byte");

  a_temp_only_on_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.last_temp != $past(st_r.last_temp)) |-> (st_r.phase == PH_READY))
    else $error("reading changed outside completion");
`endif

endmodule
